FILE: design/wfft_pkg.sv
// ----------------------------------------------------------------------------
// Flow filter table package
// Shared types, codes and constants of the wildcard flow filter table.
// ----------------------------------------------------------------------------
package wfft_pkg;

	localparam int DefaultDepth = 32;

	typedef enum logic [1:0] {
		MODE_CLASSIFY = 2'd0,
		MODE_INSTALL  = 2'd1,
		MODE_REMOVE   = 2'd2,
		MODE_UNUSED   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_MATCH     = 3'd0,
		ST_NOMATCH   = 3'd1,
		ST_INSTALLED = 3'd2,
		ST_FULL      = 3'd3,
		ST_REMOVED   = 3'd4,
		ST_NOTINST   = 3'd5
	} status_t;

	typedef struct packed {
		logic load;
		logic scan_clear;
		logic scan_step;
		logic write_entry;
		logic clear_valid;
	} ctrl_cmd_t;

	typedef struct packed {
		logic hit;
		logic valid;
		logic scan_done;
		logic free_found;
		logic remove_ok;
	} ctrl_stat_t;

endpackage

FILE: design/wfft_datapath.sv
// ----------------------------------------------------------------------------
// Flow filter table datapath
// Holds the filter memory, valid bits, the request register and scan index.
// ----------------------------------------------------------------------------
module wfft_datapath import wfft_pkg::*; #(
	parameter int TABLE_DEPTH = DefaultDepth,
	localparam int IW = $clog2(TABLE_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        cmd,
	output ctrl_stat_t       stat,
	output logic [IW-1:0]    index,
	output logic [IW-1:0]    free_index,
	output logic [IW-1:0]    remove_index,
	input  logic [31:0]      source_address,
	input  logic [31:0]      dest_address,
	input  logic [15:0]      source_port,
	input  logic [15:0]      dest_port,
	input  logic             check_ident,
	input  logic [15:0]      ident_low,
	input  logic [15:0]      ident_high,
	input  logic [4:0]       slot
);

	logic [31:0] sa_q, da_q;
	logic [15:0] sp_q, dp_q, ilo_q, ihi_q;
	logic        chk_q;
	logic [4:0]  slot_q;
	logic [IW-1:0] slot_idx;
	logic [IW:0] idx_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [IW-1:0] free_idx;
	logic        free_any;

	logic [31:0] mem_sa [TABLE_DEPTH];
	logic [31:0] mem_da [TABLE_DEPTH];
	logic [31:0] mem_pt [TABLE_DEPTH];
	logic [32:0] mem_id [TABLE_DEPTH];
	logic [31:0] rd_sa, rd_da, rd_pt;
	logic [32:0] rd_id;
	logic        rd_valid_s1;
	logic        rd_last_s1;
	logic        slot_in_range;

	assign slot_idx = IW'(slot_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sa_q <= source_address;
			da_q <= dest_address;
			sp_q <= source_port;
			dp_q <= dest_port;
			chk_q <= check_ident;
			ilo_q <= ident_low;
			ihi_q <= ident_high;
			slot_q <= slot;
		end
		if (cmd.write_entry) begin
			mem_sa[free_idx] <= sa_q;
			mem_da[free_idx] <= da_q;
			mem_pt[free_idx] <= {sp_q, dp_q};
			mem_id[free_idx] <= {chk_q, ilo_q, ihi_q};
		end
		rd_sa <= mem_sa[idx_q[IW-1:0]];
		rd_da <= mem_da[idx_q[IW-1:0]];
		rd_pt <= mem_pt[idx_q[IW-1:0]];
		rd_id <= mem_id[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			idx_q <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1 <= 1'b0;
			index <= '0;
		end else begin
			if (cmd.scan_clear) begin
				idx_q <= '0;
				rd_valid_s1 <= 1'b0;
				rd_last_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				rd_valid_s1 <= (idx_q < (IW+1)'(TABLE_DEPTH)) && valid_q[idx_q[IW-1:0]];
				rd_last_s1 <= idx_q == (IW+1)'(TABLE_DEPTH - 1);
				index <= idx_q[IW-1:0];
				if (idx_q < (IW+1)'(TABLE_DEPTH)) idx_q <= idx_q + 1'b1;
			end
			if (cmd.write_entry) valid_q[free_idx] <= 1'b1;
			if (cmd.clear_valid) valid_q[slot_idx] <= 1'b0;
		end
	end

	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IW'(i);
				free_any = 1'b1;
			end
		end
	end

	always_comb begin
		if (TABLE_DEPTH >= 32) slot_in_range = 1'b1;
		else slot_in_range = 32'(slot_q) < TABLE_DEPTH;
	end

	logic match;
	always_comb begin
		match = rd_valid_s1;
		if (rd_sa != 32'd0 && rd_sa != sa_q) match = 1'b0;
		if (rd_da != 32'd0 && rd_da != da_q) match = 1'b0;
		if (rd_pt[31:16] != 16'd0 && rd_pt[31:16] != sp_q) match = 1'b0;
		if (rd_pt[15:0] != 16'd0 && rd_pt[15:0] != dp_q) match = 1'b0;
		if (rd_id[32] && (ilo_q < rd_id[31:16] || ilo_q > rd_id[15:0])) match = 1'b0;
	end

	assign stat.hit = match;
	assign stat.valid = rd_valid_s1;
	assign stat.scan_done = rd_last_s1;
	assign stat.free_found = free_any;
	assign stat.remove_ok = slot_in_range && valid_q[slot_idx];
	assign free_index = free_idx;
	assign remove_index = slot_idx;

endmodule

FILE: design/wfft_ctrl.sv
// ----------------------------------------------------------------------------
// Flow filter table controller
// Sequences install, remove and classify transactions and drives results.
// ----------------------------------------------------------------------------
module wfft_ctrl import wfft_pkg::*; #(
	parameter int TABLE_DEPTH = DefaultDepth,
	localparam int IW = $clog2(TABLE_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    mode,
	output logic          busy,
	output ctrl_cmd_t     cmd,
	input  ctrl_stat_t    stat,
	input  logic [IW-1:0] index,
	input  logic [IW-1:0] free_index,
	input  logic [IW-1:0] remove_index,
	output logic          strobe,
	output logic [2:0]    status,
	output logic [4:0]    slot_out,
	output logic          last
);

	typedef enum logic [2:0] {S_IDLE, S_INSTALL, S_REMOVE, S_SCAN, S_DRAIN} state_t;
	state_t state_q;
	logic any_q;
	logic pend_q;
	logic [IW-1:0] pend_idx_q;
	logic accept;

	assign accept = start && !busy;

	always_comb begin
		cmd = '0;
		cmd.load = accept;
		cmd.scan_clear = accept;
		cmd.scan_step = (state_q == S_SCAN);
		cmd.write_entry = (state_q == S_INSTALL) && stat.free_found;
		cmd.clear_valid = (state_q == S_REMOVE) && stat.remove_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy <= 1'b0;
			strobe <= 1'b0;
			status <= ST_NOMATCH;
			slot_out <= '0;
			last <= 1'b0;
			any_q <= 1'b0;
			pend_q <= 1'b0;
			pend_idx_q <= '0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						any_q <= 1'b0;
						pend_q <= 1'b0;
						case (mode)
							MODE_CLASSIFY: begin state_q <= S_SCAN; busy <= 1'b1; end
							MODE_INSTALL: begin state_q <= S_INSTALL; busy <= 1'b1; end
							MODE_REMOVE: begin state_q <= S_REMOVE; busy <= 1'b1; end
							default: ;
						endcase
					end
				end
				S_INSTALL: begin
					strobe <= 1'b1;
					last <= 1'b1;
					status <= stat.free_found ? ST_INSTALLED : ST_FULL;
					slot_out <= stat.free_found ? 5'(free_index) : 5'd0;
					state_q <= S_IDLE;
					busy <= 1'b0;
				end
				S_REMOVE: begin
					strobe <= 1'b1;
					last <= 1'b1;
					status <= stat.remove_ok ? ST_REMOVED : ST_NOTINST;
					slot_out <= stat.remove_ok ? 5'(remove_index) : 5'd0;
					state_q <= S_IDLE;
					busy <= 1'b0;
				end
				S_SCAN, S_DRAIN: begin
					if (stat.hit) begin
						if (pend_q) begin
							strobe <= 1'b1;
							status <= ST_MATCH;
							slot_out <= 5'(pend_idx_q);
							last <= 1'b0;
						end
						pend_q <= 1'b1;
						pend_idx_q <= index;
						any_q <= 1'b1;
					end
					if (state_q == S_DRAIN) begin
						strobe <= 1'b1;
						last <= 1'b1;
						status <= any_q ? ST_MATCH : ST_NOMATCH;
						slot_out <= any_q ? 5'(pend_idx_q) : 5'd0;
						state_q <= S_IDLE;
						busy <= 1'b0;
					end else if (stat.scan_done) begin
						if (stat.hit) begin
							if (pend_q) state_q <= S_DRAIN;
							else begin
								strobe <= 1'b1;
								last <= 1'b1;
								status <= ST_MATCH;
								slot_out <= 5'(index);
								state_q <= S_IDLE;
								busy <= 1'b0;
							end
						end else begin
							strobe <= 1'b1;
							last <= 1'b1;
							status <= pend_q ? ST_MATCH : ST_NOMATCH;
							slot_out <= pend_q ? 5'(pend_idx_q) : 5'd0;
							state_q <= S_IDLE;
							busy <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: design/wildcard_flow_filter_table.sv
// ----------------------------------------------------------------------------
// Wildcard flow filter table
// Installs, removes and classifies against a table of wildcard flow filters.
// ----------------------------------------------------------------------------
// Install and remove each end in a single result on strobe with last set.
// Classify walks the table one slot per cycle through a registered memory
// read; when the last slot matches after an earlier match it passes through
// a drain state before its final result. Results leave on strobe in ascending
// slot order, one per cycle at most, and cannot be held off.
module wildcard_flow_filter_table import wfft_pkg::*; #(
	parameter int TABLE_DEPTH = DefaultDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] source_address,
	input  logic [31:0] dest_address,
	input  logic [15:0] source_port,
	input  logic [15:0] dest_port,
	input  logic        check_ident,
	input  logic [15:0] ident_low,
	input  logic [15:0] ident_high,
	input  logic [4:0]  slot,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [4:0]  slot_out,
	output logic        last
);

	localparam int IW = $clog2(TABLE_DEPTH);
	ctrl_cmd_t cmd;
	ctrl_stat_t stat;
	logic [IW-1:0] index, free_index, remove_index;

	wfft_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .stat, .index, .free_index, .remove_index,
		.source_address, .dest_address, .source_port, .dest_port,
		.check_ident, .ident_low, .ident_high, .slot
	);

	wfft_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
		.clk, .arst_n, .start, .mode, .busy, .cmd, .stat, .index,
		.free_index, .remove_index, .strobe, .status, .slot_out, .last
	);

	a_no_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!busy) && !$past(start) |-> !strobe)
		else $error("result without a transaction");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last)
		else $error("transaction ended without a final result");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("final result while still busy");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Flow filter table testbench
// Drives install, remove and classify transactions into the filter table,
// predicts every result from a local copy of the table, and checks each
// strobed result in order against the expected queue.
// ----------------------------------------------------------------------------
module tb;
	import wfft_pkg::*;

	localparam int Depth = DefaultDepth;

	typedef struct packed {
		status_t    status;
		logic [4:0] slot_out;
		logic       last;
	} result_t;

	typedef struct packed {
		logic        check;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] id_lo;
		logic [15:0] id_hi;
	} filter_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [31:0] source_address;
	logic [31:0] dest_address;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic        check_ident;
	logic [15:0] ident_low;
	logic [15:0] ident_high;
	logic [4:0]  slot;
	logic        strobe;
	logic [2:0]  status;
	logic [4:0]  slot_out;
	logic        last;

	logic    in_use [Depth];
	filter_t filters [Depth];
	result_t pending_results [$];
	int      errors;
	bit      steady;

	wildcard_flow_filter_table u_dut (.*);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic bit filter_hit(filter_t f, logic [31:0] sa, logic [31:0] da,
			logic [15:0] sp, logic [15:0] dp, logic [15:0] id);
		if (f.src_addr != 0 && f.src_addr != sa) return 0;
		if (f.dst_addr != 0 && f.dst_addr != da) return 0;
		if (f.src_port != 0 && f.src_port != sp) return 0;
		if (f.dst_port != 0 && f.dst_port != dp) return 0;
		if (f.check && (id < f.id_lo || id > f.id_hi)) return 0;
		return 1;
	endfunction

	task automatic predict_table_op();
		int hits;
		result_t r;
		hits = 0;
		case (mode_t'(mode))
			MODE_CLASSIFY: begin
				for (int i = 0; i < Depth; i++) begin
					if (in_use[i] && filter_hit(filters[i], source_address, dest_address,
							source_port, dest_port, ident_low)) begin
						r = '{ST_MATCH, 5'(i), 1'b0};
						pending_results.push_back(r);
						hits++;
					end
				end
				if (hits == 0) begin
					r = '{ST_NOMATCH, 5'd0, 1'b1};
					pending_results.push_back(r);
				end else begin
					pending_results[$].last = 1'b1;
				end
			end
			MODE_INSTALL: begin
				r = '{ST_FULL, 5'd0, 1'b1};
				for (int i = 0; i < Depth; i++) begin
					if (!in_use[i]) begin
						in_use[i] = 1'b1;
						filters[i] = '{check_ident, source_address, dest_address,
							source_port, dest_port, ident_low, ident_high};
						r = '{ST_INSTALLED, 5'(i), 1'b1};
						break;
					end
				end
				pending_results.push_back(r);
			end
			MODE_REMOVE: begin
				if (slot < Depth && in_use[slot]) begin
					in_use[slot] = 1'b0;
					r = '{ST_REMOVED, slot, 1'b1};
				end else begin
					r = '{ST_NOTINST, 5'd0, 1'b1};
				end
				pending_results.push_back(r);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status=%0d slot=%0d last=%0d",
					$time, status, slot_out, last);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
					errors++;
				end
				if (slot_out !== exp_r.slot_out) begin
					$display("%0t: slot_out expected %0d actual %0d", $time,
						exp_r.slot_out, slot_out);
					errors++;
				end
				if (last !== exp_r.last) begin
					$display("%0t: last expected %0d actual %0d", $time, exp_r.last, last);
					errors++;
				end
			end
		end
	end

	task automatic send_op(mode_t m, logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
			logic [15:0] dp, logic chk, logic [15:0] lo, logic [15:0] hi, logic [4:0] s);
		if (!steady) begin
			while ($urandom_range(99) < 13) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
		start <= 1'b1;
		mode <= m;
		source_address <= sa;
		dest_address <= da;
		source_port <= sp;
		dest_port <= dp;
		check_ident <= chk;
		ident_low <= lo;
		ident_high <= hi;
		slot <= s;
		do @(posedge clk); while (busy);
		predict_table_op();
		@(negedge clk);
	endtask

	task automatic send_install(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
			logic [15:0] dp, logic chk, logic [15:0] lo, logic [15:0] hi);
		send_op(MODE_INSTALL, sa, da, sp, dp, chk, lo, hi, 5'($urandom));
	endtask

	task automatic send_classify(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
			logic [15:0] dp, logic [15:0] id);
		send_op(MODE_CLASSIFY, sa, da, sp, dp, 1'($urandom), id, 16'($urandom),
			5'($urandom));
	endtask

	task automatic send_remove(logic [4:0] s);
		send_op(MODE_REMOVE, $urandom, $urandom, 16'($urandom), 16'($urandom),
			1'($urandom), 16'($urandom), 16'($urandom), s);
	endtask

	task automatic test_directed();
		send_classify(32'h0A000001, 32'h0A000002, 16'd80, 16'd443, 16'd5);
		send_install(32'h0A000001, 0, 0, 0, 1'b0, 0, 0);
		send_install(0, 32'hFFFFFFFF, 16'hFFFF, 0, 1'b1, 16'd10, 16'd20);
		send_install(0, 0, 0, 16'hFFFF, 1'b1, 16'd30, 16'd20);
		send_install(0, 0, 0, 0, 1'b1, 16'd0, 16'hFFFF);
		send_classify(32'h0A000001, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'd10);
		send_classify(32'h0A000001, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'd20);
		send_classify(32'h0A000001, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'd21);
		send_classify(32'hFFFFFFFF, 0, 0, 16'hFFFF, 16'd25);
		send_op(MODE_UNUSED, '1, '1, '1, '1, 1'b1, '1, '1, '1);
		send_remove(5'd3);
		send_remove(5'd3);
		send_remove(5'd31);
		send_classify(0, 0, 0, 0, 0);
	endtask

	task automatic test_full_table();
		for (int i = 0; i < Depth + 2; i++)
			send_install(0, 0, 0, 0, 1'b0, 0, 0);
		send_classify($urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
		for (int i = 0; i < Depth; i++)
			send_remove(5'(i));
	endtask

	task automatic test_random(int count);
		int pick;
		logic [31:0] sa, da;
		logic [15:0] sp, dp, lo;
		for (int n = 0; n < count; n++) begin
			steady = (n >= count / 3 && n < count / 2);
			pick = $urandom_range(99);
			sa = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1)) ? $urandom : 32'(
				$urandom_range(3)));
			da = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1)) ? $urandom : 32'(
				$urandom_range(3)));
			sp = ($urandom_range(2) == 0) ? 0 : 16'($urandom_range(3));
			dp = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1)) ? 16'($urandom) : 16'(
				$urandom_range(3)));
			lo = 16'($urandom);
			if (pick < 35)
				send_install(sa, da, sp, dp, 1'($urandom), lo,
					lo + 16'($urandom_range(300)));
			else if (pick < 55)
				send_remove(5'($urandom));
			else if (pick < 97)
				send_classify(sa | 32'($urandom_range(3) == 0), da, sp, dp,
					$urandom_range(1) ? lo : 16'($urandom));
			else
				send_op(MODE_UNUSED, $urandom, $urandom, 16'($urandom), 16'($urandom),
					1'($urandom), 16'($urandom), 16'($urandom), 5'($urandom));
		end
		steady = 1'b0;
	endtask

	initial begin
		errors = 0;
		steady = 1'b0;
		for (int i = 0; i < Depth; i++) in_use[i] = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_CLASSIFY;
		source_address = '0;
		dest_address = '0;
		source_port = '0;
		dest_port = '0;
		check_ident = 1'b0;
		ident_low = '0;
		ident_high = '0;
		slot = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_full_table();
		test_random(20);
		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (Depth + 10) @(negedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
